// File: rtl/ppc_pkg.sv
//------------------------------------------------------------------------------
// ppc_pkg
// Shared types and constants of the preemptive priority completion block.
//------------------------------------------------------------------------------
package ppc_pkg;

	localparam int TAG_W   = 16;
	localparam int TIME_W  = 40;
	localparam int WORD_W  = 32;

	localparam logic CMD_ARRIVE = 1'b0;
	localparam logic CMD_FLUSH  = 1'b1;

	localparam logic STATUS_DONE    = 1'b0;
	localparam logic STATUS_DROPPED = 1'b1;

	typedef struct packed {
		logic              cmd;
		logic [WORD_W-1:0] arrival_time;
		logic [WORD_W-1:0] work_length;
		logic [WORD_W-1:0] priority_req;
		logic [TAG_W-1:0]  task_tag;
	} ppc_in_t;

	typedef struct packed {
		logic [TAG_W-1:0]  done_tag;
		logic [TIME_W-1:0] finish_time;
		logic              status;
		logic              last;
	} ppc_out_t;

endpackage

// File: rtl/ppc_stream_if.sv
//------------------------------------------------------------------------------
// ppc_stream_if
// Valid/ready channel carrying one payload item.
//------------------------------------------------------------------------------
interface ppc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/preemptive_priority_completion.sv
//------------------------------------------------------------------------------
// preemptive_priority_completion
// Single preemptive priority server; arrivals advance the clock and retire
// finished tasks, flush drains the store in priority order.
//------------------------------------------------------------------------------
// Each retired task takes a scan through the registered store read, a decide
// step, an emit step and a compaction of the entries above its slot; an
// arrival ends with a store step, after a last scan and decide if tasks
// remain. One item is in work at a time; input is not ready until all its
// results have been taken. Reset clears clock and count; store contents are
// undefined until written.
module preemptive_priority_completion
	import ppc_pkg::*;
#(
	parameter int STORE_DEPTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	ppc_stream_if.sink   in_ch,
	ppc_stream_if.source out_ch
);

	localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CNT_W = $clog2(STORE_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_DECIDE, ST_EMIT, ST_SHIFT, ST_STORE
	} state_t;

	// task store
	logic [WORD_W-1:0] prio_mem [STORE_DEPTH];
	logic [WORD_W-1:0] rem_mem  [STORE_DEPTH];
	logic [TAG_W-1:0]  tag_mem  [STORE_DEPTH];

	state_t             state_q;
	logic [TIME_W-1:0]  clock_q;
	logic [CNT_W-1:0]   count_q;
	ppc_in_t            item_q;
	logic [TIME_W-1:0]  target_q;
	logic [CNT_W-1:0]   scan_q;
	logic [IDX_W-1:0]   best_q;
	logic [WORD_W-1:0]  best_prio_q;
	logic [TAG_W-1:0]   best_tag_q;
	logic [WORD_W-1:0]  best_rem_q;
	logic               emit_last_q;
	logic               held_q;
	logic               out_valid_q;
	ppc_out_t           out_q;

	// registered store read port
	logic [IDX_W-1:0]   rd_addr;
	logic               rv_q;
	logic [IDX_W-1:0]   rd_idx_q;
	logic [WORD_W-1:0]  rd_prio_q;
	logic [WORD_W-1:0]  rd_rem_q;
	logic [TAG_W-1:0]   rd_tag_q;

	// compare unit: fetched entry beats current best
	logic [IDX_W-1:0]    scan_idx;
	logic                beats;
	logic [TIME_W:0]     end_sum;
	logic [TIME_W-1:0]   tgt_in;
	logic                slot_free;
	logic                out_set;

	assign scan_idx = scan_q[IDX_W-1:0];
	assign beats = (rd_prio_q > best_prio_q) ||
		((rd_prio_q == best_prio_q) && (rd_tag_q < best_tag_q));
	assign end_sum = {1'b0, clock_q} + {{(TIME_W+1-WORD_W){1'b0}}, best_rem_q};
	assign tgt_in = ({{(TIME_W-WORD_W){1'b0}}, in_ch.payload.arrival_time} > clock_q) ?
		{{(TIME_W-WORD_W){1'b0}}, in_ch.payload.arrival_time} : clock_q;
	assign slot_free = !out_valid_q || out_ch.ready;

	assign in_ch.ready    = (state_q == ST_IDLE) && !out_valid_q;
	assign out_ch.valid   = out_valid_q;
	assign out_ch.payload = out_q;

	// read address per state
	always_comb begin
		case (state_q)
			ST_SCAN:  rd_addr = scan_idx;
			ST_SHIFT: rd_addr = IDX_W'(scan_q + CNT_W'(1));
			default:  rd_addr = '0;
		endcase
	end

	// output valid goes up when a result is presented
	always_comb begin
		case (state_q)
			ST_EMIT:  out_set = held_q || (slot_free && item_q.cmd == CMD_FLUSH);
			ST_STORE: out_set = held_q || ((count_q >= CNT_W'(STORE_DEPTH)) && slot_free);
			default:  out_set = 1'b0;
		endcase
	end

	// store read register
	always_ff @(posedge clk) begin
		rd_prio_q <= prio_mem[rd_addr];
		rd_rem_q  <= rem_mem[rd_addr];
		rd_tag_q  <= tag_mem[rd_addr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			clock_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			held_q      <= 1'b0;
			rv_q        <= 1'b0;
		end else begin
			if (out_set)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ch.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						item_q   <= in_ch.payload;
						target_q <= tgt_in;
						scan_q   <= '0;
						rv_q     <= 1'b0;
						emit_last_q <= 1'b0;
						if (count_q != '0)
							state_q <= ST_SCAN;
						else if (in_ch.payload.cmd == CMD_ARRIVE) begin
							clock_q <= tgt_in;
							state_q <= ST_STORE;
						end
					end
				end
				ST_SCAN: begin
					// compare the entry fetched last cycle, fetch the next
					if (rv_q && (rd_idx_q == '0 || beats)) begin
						best_q      <= rd_idx_q;
						best_prio_q <= rd_prio_q;
						best_tag_q  <= rd_tag_q;
						best_rem_q  <= rd_rem_q;
					end
					if (scan_q < count_q) begin
						rv_q     <= 1'b1;
						rd_idx_q <= scan_idx;
						scan_q   <= scan_q + CNT_W'(1);
					end else begin
						rv_q <= 1'b0;
						if (!rv_q)
							state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (item_q.cmd == CMD_FLUSH || end_sum <= {1'b0, target_q}) begin
						clock_q <= end_sum[TIME_W-1:0];
						scan_q  <= CNT_W'(best_q);
						rv_q    <= 1'b0;
						count_q <= count_q - CNT_W'(1);
						emit_last_q <= (item_q.cmd == CMD_FLUSH) && (count_q == CNT_W'(1));
						state_q <= ST_EMIT;
					end else begin
						// preempt: partly serve the top task
						rem_mem[best_q] <= best_rem_q - WORD_W'(target_q - clock_q);
						clock_q <= target_q;
						state_q <= ST_STORE;
					end
				end
				ST_EMIT: begin
					// an arrival holds its newest result until it knows if it is last
					if (held_q) begin
						held_q <= 1'b0;
					end else if (slot_free) begin
						out_q.done_tag    <= best_tag_q;
						out_q.finish_time <= clock_q;
						out_q.status      <= STATUS_DONE;
						out_q.last        <= emit_last_q;
						if (item_q.cmd == CMD_ARRIVE)
							held_q <= 1'b1;
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					// compact one entry per cycle over the retired slot
					if (rv_q) begin
						prio_mem[rd_idx_q - IDX_W'(1)] <= rd_prio_q;
						rem_mem[rd_idx_q - IDX_W'(1)]  <= rd_rem_q;
						tag_mem[rd_idx_q - IDX_W'(1)]  <= rd_tag_q;
					end
					if (scan_q < count_q) begin
						rv_q     <= 1'b1;
						rd_idx_q <= IDX_W'(scan_q + CNT_W'(1));
						scan_q   <= scan_q + CNT_W'(1);
					end else begin
						rv_q <= 1'b0;
						if (!rv_q) begin
							scan_q <= '0;
							if (count_q != '0)
								state_q <= ST_SCAN;
							else if (item_q.cmd == CMD_FLUSH)
								state_q <= ST_IDLE;
							else begin
								clock_q <= target_q;
								state_q <= ST_STORE;
							end
						end
					end
				end
				ST_STORE: begin
					if (count_q >= CNT_W'(STORE_DEPTH)) begin
						if (held_q) begin
							held_q <= 1'b0;
						end else if (slot_free) begin
							out_q.done_tag    <= item_q.task_tag;
							out_q.finish_time <= clock_q;
							out_q.status      <= STATUS_DROPPED;
							out_q.last        <= 1'b1;
							state_q <= ST_IDLE;
						end
					end else begin
						prio_mem[count_q[IDX_W-1:0]] <= item_q.priority_req;
						rem_mem[count_q[IDX_W-1:0]]  <= item_q.work_length;
						tag_mem[count_q[IDX_W-1:0]]  <= item_q.task_tag;
						count_q <= count_q + CNT_W'(1);
						// held result is the final one of this arrival
						if (held_q) begin
							out_q.last <= 1'b1;
							held_q     <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: tb/sv/ppc_checker.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// ppc_checker
// Watches both channels of the priority server and keeps its own copy of
// the pending store. It works out the completions of every accepted item
// and compares each returned result against the oldest one still expected.
//------------------------------------------------------------------------------
module ppc_checker
	import ppc_pkg::*;
#(
	parameter int STORE_DEPTH = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_ready,
	input  ppc_in_t  in_item,
	input  logic     out_valid,
	input  logic     out_ready,
	input  ppc_out_t out_item,
	output int       fail_count,
	output int       open_count,
	output int       done_count,
	output int       drop_count
);

	// Model of the server
	logic [63:0]       srv_clock;
	int                task_cnt;
	logic [WORD_W-1:0] task_prio [STORE_DEPTH];
	logic [WORD_W-1:0] task_left [STORE_DEPTH];
	logic [TAG_W-1:0]  task_id   [STORE_DEPTH];

	ppc_out_t completions_q[$];

	assign open_count = completions_q.size();

	// Slot of the task that runs next: highest priority, then lower tag
	function automatic int next_slot();
		int b;
		b = 0;
		for (int i = 1; i < task_cnt; i++) begin
			if (task_prio[i] > task_prio[b] ||
			    (task_prio[i] == task_prio[b] && task_id[i] < task_id[b]))
				b = i;
		end
		return b;
	endfunction

	// Retire the task in slot k, keeping arrival order of the rest
	function automatic void retire(int k, logic status);
		ppc_out_t r;
		r.done_tag    = task_id[k];
		r.finish_time = srv_clock[TIME_W-1:0];
		r.status      = status;
		r.last        = 1'b0;
		completions_q.push_back(r);
		for (int j = k; j < task_cnt - 1; j++) begin
			task_prio[j] = task_prio[j+1];
			task_left[j] = task_left[j+1];
			task_id[j]   = task_id[j+1];
		end
		task_cnt--;
	endfunction

	// Work out every completion caused by one item
	function automatic void predict_completions(ppc_in_t it);
		int          b;
		int          n0;
		logic [63:0] target;
		ppc_out_t    r;
		n0 = completions_q.size();
		if (it.cmd == CMD_FLUSH) begin
			while (task_cnt > 0) begin
				b = next_slot();
				srv_clock = (srv_clock + task_left[b]) & 64'hFF_FFFF_FFFF;
				retire(b, STATUS_DONE);
			end
		end else begin
			target = (64'(it.arrival_time) > srv_clock) ? 64'(it.arrival_time) : srv_clock;
			while (task_cnt > 0) begin
				b = next_slot();
				if (srv_clock + task_left[b] > target)
					break;
				srv_clock = srv_clock + task_left[b];
				retire(b, STATUS_DONE);
			end
			// partly served task keeps what is left
			if (task_cnt > 0) begin
				b = next_slot();
				task_left[b] = task_left[b] - WORD_W'(target - srv_clock);
			end
			srv_clock = target & 64'hFF_FFFF_FFFF;
			if (task_cnt >= STORE_DEPTH) begin
				r.done_tag    = it.task_tag;
				r.finish_time = srv_clock[TIME_W-1:0];
				r.status      = STATUS_DROPPED;
				r.last        = 1'b0;
				completions_q.push_back(r);
			end else begin
				task_left[task_cnt] = it.work_length;
				task_prio[task_cnt] = it.priority_req;
				task_id[task_cnt]   = it.task_tag;
				task_cnt++;
			end
		end
		if (completions_q.size() > n0)
			completions_q[completions_q.size()-1].last = 1'b1;
	endfunction

	// Compare results, then take in new items
	always @(posedge clk or negedge arst_n) begin
		ppc_out_t exp_r;
		if (!arst_n) begin
			srv_clock  = '0;
			task_cnt   = 0;
			fail_count = 0;
			done_count = 0;
			drop_count = 0;
			completions_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (completions_q.size() == 0) begin
					$error("unexpected result: tag %0h time %0h", out_item.done_tag,
					       out_item.finish_time);
					fail_count++;
				end else begin
					exp_r = completions_q.pop_front();
					if (out_item.done_tag !== exp_r.done_tag) begin
						$error("done_tag: expected %0h, got %0h", exp_r.done_tag,
						       out_item.done_tag);
						fail_count++;
					end
					if (out_item.finish_time !== exp_r.finish_time) begin
						$error("finish_time: expected %0h, got %0h", exp_r.finish_time,
						       out_item.finish_time);
						fail_count++;
					end
					if (out_item.status !== exp_r.status) begin
						$error("status: expected %0b, got %0b", exp_r.status,
						       out_item.status);
						fail_count++;
					end
					if (out_item.last !== exp_r.last) begin
						$error("last: expected %0b, got %0b", exp_r.last, out_item.last);
						fail_count++;
					end
					if (exp_r.status == STATUS_DROPPED)
						drop_count++;
					else
						done_count++;
				end
			end
			if (in_valid && in_ready)
				predict_completions(in_item);
		end
	end

endmodule

// File: tb/sv/tb_preemptive_priority_completion.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb_preemptive_priority_completion
// Drives task arrivals and flushes into the priority server under several
// idling mixes, a long output hold-off and a store-overflow burst; the
// checker beside the block predicts and compares every completion.
//------------------------------------------------------------------------------
module tb_preemptive_priority_completion;
	import ppc_pkg::*;

	localparam int DEPTH     = 64;
	localparam int MAX_CYCLE = 10000000;

	logic clk;
	logic arst_n;

	ppc_stream_if #(.payload_t(ppc_in_t))  task_ch ();
	ppc_stream_if #(.payload_t(ppc_out_t)) done_ch ();

	preemptive_priority_completion #(.STORE_DEPTH(DEPTH)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (task_ch),
		.out_ch (done_ch)
	);

	int fail_count, open_count, done_count, drop_count;

	ppc_checker #(.STORE_DEPTH(DEPTH)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (task_ch.valid),
		.in_ready   (task_ch.ready),
		.in_item    (task_ch.payload),
		.out_valid  (done_ch.valid),
		.out_ready  (done_ch.ready),
		.out_item   (done_ch.payload),
		.fail_count (fail_count),
		.open_count (open_count),
		.done_count (done_count),
		.drop_count (drop_count)
	);

	int          send_idle_pct;
	int          recv_stall_pct;
	logic        hold_toggle;
	logic [31:0] now_t;
	int          item_count;
	int          flush_count;

	// Clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		int cyc;
		cyc++;
		if (cyc > MAX_CYCLE) begin
			$display("[preemptive_priority_completion] ERROR");
			$finish;
		end
	end

	// Result receiver with random stalls and one long hold-off on request
	always @(posedge clk) begin
		int   hold_left;
		logic seen_toggle;
		if (!arst_n) begin
			done_ch.ready <= 1'b0;
			seen_toggle = hold_toggle;
		end else if (seen_toggle != hold_toggle) begin
			seen_toggle = hold_toggle;
			hold_left = 3000;
			done_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			done_ch.ready <= 1'b0;
		end else begin
			done_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Offer one item; valid stays high on return
	task automatic offer(ppc_in_t it);
		task_ch.valid   <= 1'b1;
		task_ch.payload <= it;
		do @(posedge clk); while (!task_ch.ready);
		item_count++;
		if (it.cmd == CMD_FLUSH)
			flush_count++;
	endtask

	// Random sender gap after an item
	task automatic maybe_idle();
		if ($urandom_range(99) < send_idle_pct) begin
			task_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic send_arrival(logic [31:0] at, logic [31:0] work, logic [31:0] prio,
	                            logic [15:0] tag);
		ppc_in_t it;
		it.cmd          = CMD_ARRIVE;
		it.arrival_time = at;
		it.work_length  = work;
		it.priority_req = prio;
		it.task_tag     = tag;
		offer(it);
		maybe_idle();
	endtask

	// Flush fields carry random junk
	task automatic send_flush();
		ppc_in_t it;
		it              = ppc_in_t'({$urandom, $urandom, $urandom, $urandom});
		it.cmd          = CMD_FLUSH;
		offer(it);
		maybe_idle();
	endtask

	// Mostly ordered arrivals, narrow priorities and tags to force ties
	task automatic random_item();
		logic [31:0] prio, work, at;
		logic [15:0] tag;
		if ($urandom_range(99) < 5) begin
			send_flush();
			return;
		end
		now_t += $urandom_range(0, 40);
		at   = ($urandom_range(99) < 8) ? now_t - $urandom_range(0, 100) : now_t;
		work = ($urandom_range(99) < 5) ? $urandom_range(1, 2000) : $urandom_range(1, 60);
		prio = ($urandom_range(99) < 20) ? $urandom : $urandom_range(0, 7);
		tag  = ($urandom_range(99) < 50) ? 16'($urandom) : 16'($urandom_range(0, 15));
		send_arrival(at, work, prio, tag);
	endtask

	task automatic drain();
		task_ch.valid <= 1'b0;
		@(posedge clk);
		wait (open_count == 0);
		repeat (DEPTH * (DEPTH + 3) + 50) @(posedge clk);
	endtask

	initial begin
		task_ch.valid   = 1'b0;
		task_ch.payload = '0;
		hold_toggle     = 1'b0;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		now_t           = 0;
		item_count      = 0;
		flush_count     = 0;
		arst_n          = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty flush, ties, preemption, late arrival
		send_flush();
		send_arrival(0, 10, 5, 16'h0003);
		send_arrival(0, 10, 5, 16'h0001);
		send_arrival(0, 10, 5, 16'h0001);
		send_arrival(2, 4, 9, 16'h0007);
		send_arrival(1, 3, 0, 16'h0002);
		send_arrival(40, 1, 32'hFFFF_FFFF, 16'hFFFF);
		send_arrival(41, 5, 0, 16'h0000);
		send_flush();
		send_arrival(10, 7, 3, 16'h1234);
		send_arrival(200, 2, 3, 16'h1233);
		send_flush();
		now_t = 300;

		// Random phases with different idling mixes
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
				default: begin send_idle_pct = 14; recv_stall_pct = 14; end
			endcase
			repeat (30) random_item();
			// sender waits for every completion
			if (ph == 1) begin
				task_ch.valid <= 1'b0;
				@(posedge clk);
				wait (open_count == 0);
				@(posedge clk);
			end
		end

		// Overflow: fill the store without completions, then drain under a hold-off
		send_idle_pct  = 10;
		recv_stall_pct = 10;
		for (int i = 0; i < DEPTH + 2; i++)
			send_arrival(now_t, $urandom_range(1, 50), $urandom_range(0, 3),
			             16'($urandom));
		hold_toggle <= ~hold_toggle;
		send_flush();
		repeat (10) random_item();
		send_flush();

		// Extremes of every field, then the top of the arrival range
		send_arrival(32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'h0, 16'h0000);
		send_arrival(32'hFFFF_FFF8, 32'h8000_0000, 32'hFFFF_FFFF, 16'hFFFF);
		send_arrival(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h5555_AAAA, 16'hA5A5);
		send_arrival(32'h0, 32'h1, 32'hAAAA_5555, 16'h5A5A);
		send_flush();
		drain();

		$display("Covered %0d items (%0d flushes): %0d completions, %0d overflow drops.",
		         item_count, flush_count, done_count, drop_count);
		if (fail_count == 0)
			$display("[preemptive_priority_completion] OK");
		else
			$display("[preemptive_priority_completion] ERROR");
		$finish;
	end

endmodule

// File: filelist.f
rtl/ppc_pkg.sv
rtl/ppc_stream_if.sv
rtl/preemptive_priority_completion.sv
tb/sv/ppc_checker.sv
tb/sv/tb_preemptive_priority_completion.sv
